[hdl/particle_code_compressor_unit_macros.svh]
// Assertion macros shared by the particle code compressor RTL.
`ifndef PARTICLE_CODE_COMPRESSOR_UNIT_MACROS_SVH
`define PARTICLE_CODE_COMPRESSOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PCC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define PCC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/pcc_pkg.sv]
// Package with constants, tables and helper functions of the particle code compressor.
package pcc_pkg;

	localparam int IdW      = 21;
	localparam int IdxW     = 9;
	localparam int MagW     = 17;
	localparam int DigW     = 4;
	localparam int ProdW    = 36;
	localparam int SpecialN = 23;

	localparam logic [IdW-1:0] MagLimit = 21'd100000;
	localparam logic [IdW-1:0] SmallMax = 21'd100;

	// Reciprocals for exact division of values below 100000.
	localparam logic [ProdW-1:0] RecipDiv10    = 36'd52429;
	localparam logic [ProdW-1:0] RecipDiv100   = 36'd167773;
	localparam logic [ProdW-1:0] RecipDiv1000  = 36'd134218;
	localparam logic [ProdW-1:0] RecipDiv10000 = 36'd107375;
	localparam int ShDiv10    = 19;
	localparam int ShDiv100   = 24;
	localparam int ShDiv1000  = 27;
	localparam int ShDiv10000 = 30;

	localparam logic [MagW-1:0] SPECIAL_CODE [SpecialN] = '{
		17'd211, 17'd111, 17'd221, 17'd311, 17'd321, 17'd130, 17'd310, 17'd213,
		17'd113, 17'd223, 17'd313, 17'd323, 17'd2112, 17'd2212, 17'd210, 17'd2110,
		17'd2210, 17'd110, 17'd220, 17'd330, 17'd440, 17'd30443, 17'd30553
	};

	localparam logic [IdxW-1:0] SPECIAL_INDEX [SpecialN] = '{
		9'd101, 9'd111, 9'd112, 9'd102, 9'd103, 9'd221, 9'd222, 9'd121,
		9'd131, 9'd132, 9'd122, 9'd123, 9'd332, 9'd333, 9'd281, 9'd282,
		9'd283, 9'd284, 9'd285, 9'd286, 9'd287, 9'd231, 9'd235
	};

	// Set where the particle at that index has a distinct antiparticle.
	function automatic logic anti_flag(input logic [IdxW-1:0] idx);
		return idx inside {[9'd1:9'd8], [9'd11:9'd18], 9'd24, 9'd34, 9'd37,
			[9'd39:9'd40], 9'd82, [9'd84:9'd90], [9'd101:9'd110], [9'd121:9'd130],
			[9'd141:9'd150], [9'd161:9'd170], [9'd181:9'd190], [9'd201:9'd210],
			[9'd281:9'd283], 9'd306, 9'd312, [9'd314:9'd315], 9'd322,
			[9'd324:9'd325], [9'd332:9'd333], [9'd335:9'd339], [9'd341:9'd346],
			[9'd351:9'd356], [9'd361:9'd376], [9'd381:9'd386]};
	endfunction

	// (a + 1) * a * (a - 1) / 6 for a from 1 to 5.
	function automatic logic [IdxW-1:0] tri_off(input logic [DigW-1:0] d);
		logic [IdxW-1:0] v;
		case (d)
			4'd2: v = 9'd1;
			4'd3: v = 9'd4;
			4'd4: v = 9'd10;
			4'd5: v = 9'd20;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	// b * (b - 1) / 2 for b from 1 to 3.
	function automatic logic [IdxW-1:0] pair_off(input logic [DigW-1:0] d);
		logic [IdxW-1:0] v;
		case (d)
			4'd2: v = 9'd1;
			4'd3: v = 9'd3;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	// (b - 1) * (b - 2) / 2 for b from 2 to 5.
	function automatic logic [IdxW-1:0] meson_off(input logic [DigW-1:0] d);
		logic [IdxW-1:0] v;
		case (d)
			4'd3: v = 9'd1;
			4'd4: v = 9'd3;
			4'd5: v = 9'd6;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

[hdl/particle_code_compressor_unit.sv]
// Particle code compressor: five-stage pipeline from signed identifier to compressed index.
//
// Input channel: id_valid, id_stall, particle_id (21-bit two's complement code).
// Output channel: idx_valid, idx_stall, compressed_index (0 to 500, 0 meaning
// unknown code or no such antiparticle).
// A beat moves on a channel at a rising edge where valid is high and stall low.
// A beat taken at one edge passes the stage registers s1 to s4 and is presented
// on the output channel from the fifth register stage, s5.
// Throughput is one beat per cycle when not stalled; the stages are absolute
// value, reciprocal division by 10, 100, 1000 and 10000 with special code
// match, digit extraction, classification, and the antiparticle flag check.
// Valid bits travel with the data; the whole pipeline holds when a result waits
// under idx_stall, and id_stall is raised only then, so no beat is lost or
// repeated. The stages move together, so a bubble travels on with its neighbours.
// Reset clears every valid bit, so id_stall is low and a beat is accepted.
module particle_code_compressor_unit
	import pcc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   id_valid,
	output logic                   id_stall,
	input  logic signed [IdW-1:0]  particle_id,
	output logic                   idx_valid,
	input  logic                   idx_stall,
	output logic        [IdxW-1:0] compressed_index
);

	logic adv;

	logic            vld_s1, neg_s1;
	logic [IdW-1:0]  mag_s1;

	logic            vld_s2, neg_s2, zb_s2, sm_s2, sp_s2;
	logic [IdxW-1:0] spi_s2;
	logic [MagW-1:0] m_s2;
	logic [13:0]     q1_s2;
	logic [9:0]      q2_s2;
	logic [6:0]      q3_s2;
	logic [3:0]      q4_s2;

	logic            vld_s3, neg_s3, zb_s3, sm_s3, sp_s3;
	logic [IdxW-1:0] spi_s3;
	logic [6:0]      m7_s3;
	logic [DigW-1:0] r_s3, a_s3, b_s3, c_s3, s_s3;

	logic            vld_s4, neg_s4, chk_s4;
	logic [IdxW-1:0] val_s4;

	logic            vld_s5;
	logic [IdxW-1:0] idx_s5;

	logic [IdW-1:0]  pid_u, mag_c;
	logic [ProdW-1:0] p1, p2, p3, p4;
	logic            sp_hit_c;
	logic [IdxW-1:0] sp_idx_c;
	logic [MagW-1:0] s_w;
	logic [13:0]     c_w;
	logic [9:0]      b_w;
	logic [6:0]      a_w;
	logic [IdxW-1:0] cls_c;

	assign adv      = !vld_s5 || !idx_stall;
	assign id_stall = !adv;

	assign idx_valid        = vld_s5;
	assign compressed_index = idx_s5;

	assign pid_u = particle_id;
	assign mag_c = particle_id[IdW-1] ? (~pid_u + 21'd1) : pid_u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= id_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign p1 = ProdW'(mag_s1[MagW-1:0]) * RecipDiv10;
	assign p2 = ProdW'(mag_s1[MagW-1:0]) * RecipDiv100;
	assign p3 = ProdW'(mag_s1[MagW-1:0]) * RecipDiv1000;
	assign p4 = ProdW'(mag_s1[MagW-1:0]) * RecipDiv10000;

	always_comb begin
		sp_hit_c = 1'b0;
		sp_idx_c = '0;
		for (int i = 0; i < SpecialN; i++) begin
			if (mag_s1[MagW-1:0] == SPECIAL_CODE[i]) begin
				sp_hit_c = 1'b1;
				sp_idx_c = SPECIAL_INDEX[i];
			end
		end
	end

	assign s_w = m_s2 - (MagW'(q1_s2) * 17'd10);
	assign c_w = q1_s2 - (14'(q2_s2) * 14'd10);
	assign b_w = q2_s2 - (10'(q3_s2) * 10'd10);
	assign a_w = q3_s2 - (7'(q4_s2) * 7'd10);

	always_comb begin
		logic            base_ok;
		logic [IdxW-1:0] base;
		base_ok = 1'b1;
		base    = '0;
		cls_c   = '0;
		if (r_s3 == 4'd0 && s_s3 == 4'd1) begin
			base = 9'd0;
		end else if (r_s3 == 4'd0 && s_s3 == 4'd3) begin
			base = 9'd20;
		end else if (r_s3 == 4'd1 && s_s3 == 4'd3) begin
			base = 9'd40;
		end else if (r_s3 == 4'd1 && s_s3 == 4'd1) begin
			base = 9'd60;
		end else if (r_s3 == 4'd2 && s_s3 == 4'd3) begin
			base = 9'd80;
		end else if (r_s3 == 4'd0 && s_s3 == 4'd5) begin
			base = 9'd100;
		end else begin
			base_ok = 1'b0;
		end
		if (a_s3 == 4'd0) begin
			if (b_s3 == 4'd0 || b_s3 == 4'd9 || c_s3 == 4'd0 || c_s3 == 4'd9 || b_s3 < c_s3) begin
				cls_c = '0;
			end else if (b_s3 == c_s3) begin
				cls_c = (neg_s3 || !base_ok) ? '0 : 9'd110 + base + IdxW'(b_s3);
			end else if (b_s3 <= 4'd5) begin
				cls_c = !base_ok ? '0 : 9'd100 + base + meson_off(b_s3) + IdxW'(c_s3);
			end else begin
				cls_c = base_ok ? 9'd80 + IdxW'(b_s3) : '0;
			end
		end else if ((r_s3 == 4'd0 || r_s3 == 4'd1) && c_s3 == 4'd0) begin
			if (s_s3 != 4'd1 && s_s3 != 4'd3) begin
				cls_c = '0;
			end else if (a_s3 == 4'd9 || b_s3 == 4'd0 || b_s3 == 4'd9 || a_s3 < b_s3) begin
				cls_c = '0;
			end else if (s_s3 == 4'd1 && a_s3 == b_s3) begin
				cls_c = '0;
			end else begin
				cls_c = 9'd90;
			end
		end else if (r_s3 == 4'd0 && s_s3 == 4'd2) begin
			if (a_s3 == 4'd9 || b_s3 == 4'd0 || b_s3 == 4'd9 || c_s3 == 4'd9) begin
				cls_c = '0;
			end else if (a_s3 <= c_s3 || a_s3 < b_s3) begin
				cls_c = '0;
			end else if (a_s3 >= 4'd6 || b_s3 >= 4'd4 || c_s3 >= 4'd4) begin
				cls_c = 9'd80 + IdxW'(a_s3);
			end else if (b_s3 < c_s3) begin
				cls_c = 9'd300 + tri_off(a_s3) + pair_off(c_s3) + IdxW'(b_s3);
			end else begin
				cls_c = 9'd330 + tri_off(a_s3) + pair_off(b_s3) + IdxW'(c_s3);
			end
		end else if (r_s3 == 4'd0 && s_s3 == 4'd4) begin
			if (a_s3 == 4'd9 || b_s3 == 4'd0 || b_s3 == 4'd9 || c_s3 == 4'd9) begin
				cls_c = '0;
			end else if (a_s3 < b_s3 || b_s3 < c_s3) begin
				cls_c = '0;
			end else if (a_s3 >= 4'd6 || b_s3 >= 4'd4) begin
				cls_c = 9'd80 + IdxW'(a_s3);
			end else begin
				cls_c = 9'd360 + tri_off(a_s3) + pair_off(b_s3) + IdxW'(c_s3);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= particle_id[IdW-1];
			mag_s1 <= mag_c;

			neg_s2 <= neg_s1;
			zb_s2  <= (mag_s1 == '0) || (mag_s1 >= MagLimit);
			sm_s2  <= (mag_s1 <= SmallMax);
			sp_s2  <= sp_hit_c;
			spi_s2 <= sp_idx_c;
			m_s2   <= mag_s1[MagW-1:0];
			q1_s2  <= p1[ShDiv10 +: 14];
			q2_s2  <= p2[ShDiv100 +: 10];
			q3_s2  <= p3[ShDiv1000 +: 7];
			q4_s2  <= p4[ShDiv10000 +: 4];

			neg_s3 <= neg_s2;
			zb_s3  <= zb_s2;
			sm_s3  <= sm_s2;
			sp_s3  <= sp_s2;
			spi_s3 <= spi_s2;
			m7_s3  <= m_s2[6:0];
			r_s3   <= q4_s2;
			a_s3   <= a_w[DigW-1:0];
			b_s3   <= b_w[DigW-1:0];
			c_s3   <= c_w[DigW-1:0];
			s_s3   <= s_w[DigW-1:0];

			neg_s4 <= neg_s3;
			if (zb_s3) begin
				val_s4 <= '0;
				chk_s4 <= 1'b0;
			end else if (sm_s3) begin
				val_s4 <= IdxW'(m7_s3);
				chk_s4 <= 1'b1;
			end else if (sp_s3) begin
				val_s4 <= spi_s3;
				chk_s4 <= 1'b1;
			end else begin
				val_s4 <= cls_c;
				chk_s4 <= 1'b0;
			end

			idx_s5 <= (chk_s4 && neg_s4 && !anti_flag(val_s4)) ? '0 : val_s4;
		end
	end

`include "particle_code_compressor_unit_macros.svh"

	`PCC_ASSERT_IMP(a_idx_range, idx_valid, compressed_index <= 9'd500, "index above 500")
	`PCC_ASSERT_IMP(a_stall_cause, id_stall, idx_valid && idx_stall, "input stalled without output backpressure")
	`PCC_ASSERT_NXT(a_s4_moves, vld_s4 && adv, idx_valid, "stage four beat lost on advance")
	`PCC_ASSERT_NXT(a_zero_big, vld_s3 && zb_s3 && adv, val_s4 == '0 && !chk_s4, "out-of-range code not cleared")

endmodule
